/* rtl/gda_pkg.sv */
// Shared types, constants and calendar helpers for the Gregorian date unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package gda_pkg;

  // Internal year width covers every legal year limit.
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned SPAN_W  = 22;
  localparam int unsigned MUL_A_W = 16;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned SHR_W   = 5;
  localparam int unsigned ACC_W   = 27;

  localparam logic [SPAN_W-1:0] SPAN_MAX = '1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST_DEC = 5'd31;
  localparam logic [YEAR_W-1:0] YEAR_FIRST = 16'd1;

  // Multiplier operands. Division by 100 is a multiply by ceil(2^23 / 100) and a
  // shift by 23; this is exact for every 16-bit value. Shifting by 25 gives / 400.
  localparam logic [MUL_B_W-1:0] MUL_ONE         = 17'd1;
  localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR   = 17'd365;
  localparam logic [MUL_B_W-1:0] MONTHS_PER_YEAR = 17'd12;
  localparam logic [MUL_B_W-1:0] RECIP_100       = 17'd83887;
  localparam logic [SHR_W-1:0]   SHR_NONE        = 5'd0;
  localparam logic [SHR_W-1:0]   SHR_DIV4        = 5'd2;
  localparam logic [SHR_W-1:0]   SHR_DIV100      = 5'd23;
  localparam logic [SHR_W-1:0]   SHR_DIV400      = 5'd25;

  typedef enum logic [2:0] {
    KIND_ADD_DAYS   = 3'd0,
    KIND_SUB_DAYS   = 3'd1,
    KIND_DAY_SPAN   = 3'd2,
    KIND_YEAR_SPAN  = 3'd3,
    KIND_MONTH_SPAN = 3'd4
  } kind_e;

  // One command to the shared multiply-accumulate unit.
  typedef struct packed {
    logic               en;
    logic               clear;
    logic               neg;
    logic [SHR_W-1:0]   shr;
    logic [MUL_A_W-1:0] opa;
    logic [MUL_B_W-1:0] opb;
  } mac_op_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB:                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && (m > MONTH_FEB)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

/* rtl/gregorian_date_arithmetic_top.sv */
// Gregorian date unit: one request at a time under a small sequencer.
// A step of k days advances one day per cycle and stops early when the year range is left;
// a day distance takes ten passes through the shared multiply-accumulate unit.
// A new request is taken the cycle after the result is registered.
// Reset is asynchronous, active low; it clears the sequencer and the output valid.
`timescale 1ns / 1ps

module gregorian_date_arithmetic_top
  import gda_pkg::*;
#(
  parameter int unsigned STEP_BITS = 16,
  parameter int unsigned YEAR_MAX  = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [4:0]  first_day_i,
  input  logic [3:0]  first_month_i,
  input  logic [13:0] first_year_i,
  input  logic [4:0]  second_day_i,
  input  logic [3:0]  second_month_i,
  input  logic [13:0] second_year_i,
  input  logic [15:0] step_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  result_day_o,
  output logic [3:0]  result_month_o,
  output logic [13:0] result_year_o,
  output logic [21:0] span_o,
  output logic        range_error_o
);

  localparam logic [YEAR_W-1:0] YEAR_TOP = YEAR_W'(YEAR_MAX);
  localparam logic [3:0] DAY_PROG_LAST   = 4'd9;
  localparam logic [3:0] YEAR_PROG_LAST  = 4'd1;
  localparam logic [3:0] MONTH_PROG_LAST = 4'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM_A,
    S_NORM_B,
    S_NORM_C,
    S_ORDER,
    S_STEP,
    S_CALC,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [2:0]           kind_q, kind_d;
  logic [YEAR_W-1:0]    ay_q, ay_d, by_q, by_d, cy_q, cy_d;
  logic [3:0]           am_q, am_d, bm_q, bm_d, cm_q, cm_d;
  logic [4:0]           ad_q, ad_d, bd_q, bd_d, cd_q, cd_d;
  logic                 la_q, la_d, lb_q, lb_d;
  logic [STEP_BITS-1:0] k_q, k_d;
  logic [3:0]           step_q, step_d;
  logic                 err_q, err_d;

  logic                 out_valid_q, out_valid_d;
  logic [4:0]           rd_q, rd_d;
  logic [3:0]           rm_q, rm_d;
  logic [13:0]          ry_q, ry_d;
  logic [SPAN_W-1:0]    span_q, span_d;
  logic                 rerr_q, rerr_d;

  logic                 accept;
  logic [YEAR_W-1:0]    fy, sy;
  logic [3:0]           fm, sm;
  logic [4:0]           fd, sd;
  logic [4:0]           len_a, len_b, len_c;
  logic [3:0]           cm_prev;
  logic                 a_later;
  logic                 borrow_y;
  logic [SPAN_W-1:0]    span_sat;

  logic [YEAR_W-1:0]       leap_year;
  logic                    leap_q;
  mac_op_t                 mac_op;
  logic signed [ACC_W-1:0] acc;

  gda_leap u_leap (
    .clk_i  (clk_i),
    .year_i (leap_year),
    .leap_o (leap_q)
  );

  gda_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .acc_o (acc)
  );

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  // The leap result is registered and so trails its year; the second date is only
  // tested while its day is being clamped.
  assign leap_year  = (state_q == S_NORM_B) ? by_q : cy_q;

  // Clamp the raw input fields into range; days get their upper clamp later.
  always_comb begin
    fy = YEAR_W'(first_year_i);
    if (fy == '0) begin
      fy = YEAR_FIRST;
    end else if (fy > YEAR_TOP) begin
      fy = YEAR_TOP;
    end
    sy = YEAR_W'(second_year_i);
    if (sy == '0) begin
      sy = YEAR_FIRST;
    end else if (sy > YEAR_TOP) begin
      sy = YEAR_TOP;
    end
    fm = first_month_i;
    if (fm < MONTH_JAN) begin
      fm = MONTH_JAN;
    end else if (fm > MONTH_DEC) begin
      fm = MONTH_DEC;
    end
    sm = second_month_i;
    if (sm < MONTH_JAN) begin
      sm = MONTH_JAN;
    end else if (sm > MONTH_DEC) begin
      sm = MONTH_DEC;
    end
    fd = (first_day_i == '0) ? DAY_FIRST : first_day_i;
    sd = (second_day_i == '0) ? DAY_FIRST : second_day_i;
  end

  always_comb begin
    len_a    = month_len(am_q, leap_q);
    len_b    = month_len(bm_q, leap_q);
    len_c    = month_len(cm_q, leap_q);
    cm_prev  = cm_q - 4'd1;
    a_later  = {ay_q, am_q, ad_q} > {by_q, bm_q, bd_q};
    borrow_y = {am_q, ad_q} > {bm_q, bd_q};
    span_sat = (acc[ACC_W-1:SPAN_W] != '0) ? SPAN_MAX : acc[SPAN_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    ay_d        = ay_q;
    am_d        = am_q;
    ad_d        = ad_q;
    by_d        = by_q;
    bm_d        = bm_q;
    bd_d        = bd_q;
    cy_d        = cy_q;
    cm_d        = cm_q;
    cd_d        = cd_q;
    la_d        = la_q;
    lb_d        = lb_q;
    k_d         = k_q;
    step_d      = step_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_d        = rd_q;
    rm_d        = rm_q;
    ry_d        = ry_q;
    span_d      = span_q;
    rerr_d      = rerr_q;
    mac_op      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = kind_i;
          ay_d    = fy;
          am_d    = fm;
          ad_d    = fd;
          cy_d    = fy;
          cm_d    = fm;
          cd_d    = fd;
          by_d    = sy;
          bm_d    = sm;
          bd_d    = sd;
          k_d     = STEP_BITS'(step_count_i);
          err_d   = 1'b0;
          state_d = S_NORM_A;
        end
      end

      S_NORM_A: begin
        state_d = S_NORM_B;
      end

      S_NORM_B: begin
        la_d = leap_q;
        if (ad_q > len_a) begin
          ad_d = len_a;
          cd_d = len_a;
        end
        state_d = S_NORM_C;
      end

      S_NORM_C: begin
        lb_d = leap_q;
        if (bd_q > len_b) begin
          bd_d = len_b;
        end
        state_d = S_ORDER;
      end

      S_ORDER: begin
        step_d = '0;
        case (kind_q)
          KIND_ADD_DAYS, KIND_SUB_DAYS: begin
            state_d = S_STEP;
          end
          KIND_DAY_SPAN, KIND_YEAR_SPAN, KIND_MONTH_SPAN: begin
            // Earlier date goes to the a side; years are kept as year - 1,
            // which the day count needs and the differences do not notice.
            if (a_later) begin
              ay_d = by_q - YEAR_FIRST;
              am_d = bm_q;
              ad_d = bd_q;
              la_d = lb_q;
              by_d = ay_q - YEAR_FIRST;
              bm_d = am_q;
              bd_d = ad_q;
              lb_d = la_q;
            end else begin
              ay_d = ay_q - YEAR_FIRST;
              by_d = by_q - YEAR_FIRST;
            end
            state_d = S_CALC;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_STEP: begin
        if (k_q == '0) begin
          state_d = S_DONE;
        end else if (kind_q == KIND_ADD_DAYS) begin
          if ((cy_q == YEAR_TOP) && (cm_q == MONTH_DEC) && (cd_q == DAY_LAST_DEC)) begin
            err_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            k_d = k_q - STEP_BITS'(1);
            if (cd_q == len_c) begin
              cd_d = DAY_FIRST;
              if (cm_q == MONTH_DEC) begin
                cm_d = MONTH_JAN;
                cy_d = cy_q + YEAR_FIRST;
              end else begin
                cm_d = cm_q + 4'd1;
              end
            end else begin
              cd_d = cd_q + 5'd1;
            end
          end
        end else begin
          if ((cy_q == YEAR_FIRST) && (cm_q == MONTH_JAN) && (cd_q == DAY_FIRST)) begin
            err_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            k_d = k_q - STEP_BITS'(1);
            if (cd_q == DAY_FIRST) begin
              if (cm_q == MONTH_JAN) begin
                cm_d = MONTH_DEC;
                cd_d = DAY_LAST_DEC;
                cy_d = cy_q - YEAR_FIRST;
              end else begin
                cm_d = cm_prev;
                cd_d = month_len(cm_prev, leap_q);
              end
            end else begin
              cd_d = cd_q - 5'd1;
            end
          end
        end
      end

      S_CALC: begin
        mac_op.en  = 1'b1;
        mac_op.opb = MUL_ONE;
        mac_op.shr = SHR_NONE;
        step_d     = step_q + 4'd1;
        case (kind_q)
          KIND_DAY_SPAN: begin
            // Day number of the later date, less that of the earlier one:
            // 365 p + p/4 - p/100 + p/400 + days before the month + day.
            case (step_q)
              4'd0: begin
                mac_op.clear = 1'b1;
                mac_op.opa   = by_q;
                mac_op.opb   = DAYS_PER_YEAR;
              end
              4'd1: begin
                mac_op.opa = by_q;
                mac_op.shr = SHR_DIV4;
              end
              4'd2: begin
                mac_op.neg = 1'b1;
                mac_op.opa = by_q;
                mac_op.opb = RECIP_100;
                mac_op.shr = SHR_DIV100;
              end
              4'd3: begin
                mac_op.opa = by_q;
                mac_op.opb = RECIP_100;
                mac_op.shr = SHR_DIV400;
              end
              4'd4: begin
                mac_op.opa = MUL_A_W'(days_before(bm_q, lb_q)) + MUL_A_W'(bd_q);
              end
              4'd5: begin
                mac_op.neg = 1'b1;
                mac_op.opa = ay_q;
                mac_op.opb = DAYS_PER_YEAR;
              end
              4'd6: begin
                mac_op.neg = 1'b1;
                mac_op.opa = ay_q;
                mac_op.shr = SHR_DIV4;
              end
              4'd7: begin
                mac_op.opa = ay_q;
                mac_op.opb = RECIP_100;
                mac_op.shr = SHR_DIV100;
              end
              4'd8: begin
                mac_op.neg = 1'b1;
                mac_op.opa = ay_q;
                mac_op.opb = RECIP_100;
                mac_op.shr = SHR_DIV400;
              end
              default: begin
                mac_op.neg = 1'b1;
                mac_op.opa = MUL_A_W'(days_before(am_q, la_q)) + MUL_A_W'(ad_q);
              end
            endcase
            if (step_q == DAY_PROG_LAST) begin
              state_d = S_DONE;
            end
          end
          KIND_YEAR_SPAN: begin
            case (step_q)
              4'd0: begin
                mac_op.clear = 1'b1;
                mac_op.opa   = by_q - ay_q;
              end
              default: begin
                mac_op.neg = 1'b1;
                mac_op.opa = MUL_A_W'(borrow_y);
              end
            endcase
            if (step_q == YEAR_PROG_LAST) begin
              state_d = S_DONE;
            end
          end
          KIND_MONTH_SPAN: begin
            case (step_q)
              4'd0: begin
                mac_op.clear = 1'b1;
                mac_op.opa   = by_q - ay_q;
                mac_op.opb   = MONTHS_PER_YEAR;
              end
              4'd1: begin
                mac_op.opa = MUL_A_W'(bm_q);
              end
              default: begin
                mac_op.neg = 1'b1;
                mac_op.opa = MUL_A_W'(am_q) + MUL_A_W'(ad_q > bd_q);
              end
            endcase
            if (step_q == MONTH_PROG_LAST) begin
              state_d = S_DONE;
            end
          end
          default: begin
            mac_op.en = 1'b0;
            state_d   = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          rd_d        = '0;
          rm_d        = '0;
          ry_d        = '0;
          span_d      = '0;
          rerr_d      = 1'b0;
          case (kind_q)
            KIND_ADD_DAYS, KIND_SUB_DAYS: begin
              // Leaving the year range returns the normalized first date.
              if (err_q) begin
                rd_d = ad_q;
                rm_d = am_q;
                ry_d = ay_q[13:0];
              end else begin
                rd_d = cd_q;
                rm_d = cm_q;
                ry_d = cy_q[13:0];
              end
              rerr_d = err_q;
            end
            KIND_DAY_SPAN, KIND_YEAR_SPAN, KIND_MONTH_SPAN: begin
              span_d = span_sat;
            end
            default: begin
              span_d = '0;
            end
          endcase
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rd_q        <= '0;
      rm_q        <= '0;
      ry_q        <= '0;
      span_q      <= '0;
      rerr_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_q        <= rd_d;
      rm_q        <= rm_d;
      ry_q        <= ry_d;
      span_q      <= span_d;
      rerr_q      <= rerr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ay_q   <= ay_d;
    am_q   <= am_d;
    ad_q   <= ad_d;
    by_q   <= by_d;
    bm_q   <= bm_d;
    bd_q   <= bd_d;
    cy_q   <= cy_d;
    cm_q   <= cm_d;
    cd_q   <= cd_d;
    la_q   <= la_d;
    lb_q   <= lb_d;
    k_q    <= k_d;
    step_q <= step_d;
    err_q  <= err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_day_o   = rd_q;
  assign result_month_o = rm_q;
  assign result_year_o  = ry_q;
  assign span_o         = span_q;
  assign range_error_o  = rerr_q;

endmodule

/* rtl/gda_leap.sv */
// Registered leap-year test (4/100/400 rule) for one year per cycle.
// Depends on gda_pkg for the year width.
`timescale 1ns / 1ps

module gda_leap
  import gda_pkg::*;
(
  input  logic              clk_i,
  input  logic [YEAR_W-1:0] year_i,
  output logic              leap_o
);

  localparam int unsigned Q_W = YEAR_W - 2;
  // Multiplying by the inverse of 25 modulo 2^14 maps the multiples of 25
  // onto 0..655, so divisibility is one multiply and one compare.
  localparam logic [Q_W-1:0] INV_25     = 14'd7209;
  localparam logic [Q_W-1:0] MULT25_LIM = 14'd655;

  logic [Q_W-1:0] quarter;
  logic [Q_W-1:0] mix;
  logic           div25;
  logic           leap_d;
  logic           leap_q;

  always_comb begin
    quarter = year_i[YEAR_W-1:2];
    mix     = quarter * INV_25;
    div25   = (mix <= MULT25_LIM);
    leap_d  = (year_i[1:0] == 2'b00) && (!div25 || (quarter[1:0] == 2'b00));
  end

  always_ff @(posedge clk_i) begin
    leap_q <= leap_d;
  end

  assign leap_o = leap_q;

endmodule

/* rtl/gda_mac.sv */
// Shared multiply, shift and accumulate unit driven by the date sequencer.
// Depends on gda_pkg for the command struct and widths.
`timescale 1ns / 1ps

module gda_mac
  import gda_pkg::*;
(
  input  logic                    clk_i,
  input  mac_op_t                 op_i,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;

  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       prod_sh;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] acc_q;

  always_comb begin
    prod    = PROD_W'(op_i.opa) * PROD_W'(op_i.opb);
    prod_sh = prod >> op_i.shr;
    // The sequencer only issues terms that fit well below the sign bit.
    term    = $signed(prod_sh[ACC_W-1:0]);
    base    = op_i.clear ? '0 : acc_q;
    acc_d   = op_i.neg ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the Gregorian date unit: directed and random requests
// are checked against a built-in calendar predictor. Depends on gda_pkg and on
// gregorian_date_arithmetic_top.
`timescale 1ns / 1ps

module tb_top;
  import gda_pkg::*;

  localparam logic [13:0] YEAR_LIMIT   = 14'd9999;
  localparam int unsigned RANDOM_ITEMS = 73;
  localparam int unsigned TAIL_CYCLES  = 24;
  localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
  // Every request at the longest step, the longest send gap and a long output stall.
  localparam longint unsigned CYCLE_LIMIT = 64'd150 * (64'd65536 + 64'd120) * 64'd3;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } cal_date_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  d1;
    logic [3:0]  m1;
    logic [13:0] y1;
    logic [4:0]  d2;
    logic [3:0]  m2;
    logic [13:0] y2;
    logic [15:0] steps;
  } date_req_t;

  typedef struct packed {
    cal_date_t   at;
    logic [21:0] span;
    logic        range_error;
  } date_result_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  req_kind  = '0;
  logic [4:0]  req_d1    = '0;
  logic [3:0]  req_m1    = '0;
  logic [13:0] req_y1    = '0;
  logic [4:0]  req_d2    = '0;
  logic [3:0]  req_m2    = '0;
  logic [13:0] req_y2    = '0;
  logic [15:0] req_steps = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [4:0]  res_day;
  logic [3:0]  res_month;
  logic [13:0] res_year;
  logic [21:0] res_span;
  logic        res_error;

  date_result_t    pending_results[$];
  int unsigned     err_count  = 0;
  int unsigned     burst_left = 0;
  int unsigned     stall_mode = 0;
  int unsigned     stall_left = 0;
  longint unsigned cycles     = 0;

  gregorian_date_arithmetic_top #(
    .STEP_BITS(16),
    .YEAR_MAX (YEAR_LIMIT)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_stall_o    (req_stall),
    .kind_i        (req_kind),
    .first_day_i   (req_d1),
    .first_month_i (req_m1),
    .first_year_i  (req_y1),
    .second_day_i  (req_d2),
    .second_month_i(req_m2),
    .second_year_i (req_y2),
    .step_count_i  (req_steps),
    .out_valid_o   (res_valid),
    .out_stall_i   (res_stall),
    .result_day_o  (res_day),
    .result_month_o(res_month),
    .result_year_o (res_year),
    .span_o        (res_span),
    .range_error_o (res_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- calendar predictor

  function automatic bit is_leap_year(input int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    if (m == MONTH_FEB) return is_leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic cal_date_t clamp_date(input logic [4:0] d, input logic [3:0] m,
                                           input logic [13:0] y);
    cal_date_t   c;
    int unsigned len;
    c.month = m;
    if (m < MONTH_JAN) c.month = MONTH_JAN;
    if (m > MONTH_DEC) c.month = MONTH_DEC;
    c.year = y;
    if (y == 0) c.year = 14'd1;
    if (y > YEAR_LIMIT) c.year = YEAR_LIMIT;
    len = days_in(c.month, c.year);
    c.day = d;
    if (d == 0) c.day = DAY_FIRST;
    if (d > len) c.day = 5'(len);
    return c;
  endfunction

  // Day number counted from 1 January of year 1, which is day 1.
  function automatic int unsigned day_number(input cal_date_t c);
    int unsigned p;
    int unsigned s;
    p = int'(c.year) - 1;
    s = p * 365 + p / 4 - p / 100 + p / 400;
    for (int unsigned mm = 1; mm < c.month; mm++) s += days_in(mm, c.year);
    return s + c.day;
  endfunction

  function automatic cal_date_t date_at(input int unsigned s);
    cal_date_t   c;
    int unsigned z, q400, rem, cent, q4, y1, yr, mm;
    z    = s - 1;
    q400 = z / 146097;
    rem  = z % 146097;
    cent = rem / 36524;
    if (cent > 3) cent = 3;
    rem -= cent * 36524;
    q4   = rem / 1461;
    rem  = rem % 1461;
    y1   = rem / 365;
    if (y1 > 3) y1 = 3;
    rem -= y1 * 365;
    yr = q400 * 400 + cent * 100 + q4 * 4 + y1 + 1;
    mm = 1;
    while (mm < 12 && rem >= days_in(mm, yr)) begin
      rem -= days_in(mm, yr);
      mm++;
    end
    c.year  = 14'(yr);
    c.month = 4'(mm);
    c.day   = 5'(rem + 1);
    return c;
  endfunction

  function automatic bit on_or_before(input cal_date_t a, input cal_date_t b);
    if (a.year != b.year) return a.year < b.year;
    if (a.month != b.month) return a.month < b.month;
    return a.day <= b.day;
  endfunction

  function automatic date_result_t predict_date_op(input date_req_t req);
    date_result_t r;
    cal_date_t    a, b, p, n, last;
    int unsigned  s, top, span;
    a    = clamp_date(req.d1, req.m1, req.y1);
    b    = clamp_date(req.d2, req.m2, req.y2);
    r    = '0;
    span = 0;
    if (req.kind == KIND_ADD_DAYS || req.kind == KIND_SUB_DAYS) begin
      last.day   = DAY_LAST_DEC;
      last.month = MONTH_DEC;
      last.year  = YEAR_LIMIT;
      top  = day_number(last);
      s    = day_number(a);
      r.at = a;
      // Leaving the year range keeps the clamped start date and flags the error.
      if (req.kind == KIND_ADD_DAYS) begin
        if (s + req.steps > top) r.range_error = 1'b1;
        else r.at = date_at(s + req.steps);
      end else begin
        if (req.steps >= s) r.range_error = 1'b1;
        else r.at = date_at(s - req.steps);
      end
    end else if (req.kind <= KIND_MONTH_SPAN) begin
      if (on_or_before(a, b)) begin
        p = a;
        n = b;
      end else begin
        p = b;
        n = a;
      end
      case (req.kind)
        KIND_DAY_SPAN: begin
          span = day_number(n) - day_number(p);
        end
        KIND_YEAR_SPAN: begin
          span = int'(n.year) - int'(p.year);
          if (p.month > n.month || (p.month == n.month && p.day > n.day)) span--;
        end
        default: begin
          span = (int'(n.year) - int'(p.year)) * 12 + int'(n.month) - int'(p.month);
          if (p.day > n.day) span--;
        end
      endcase
      if (span > SPAN_MAX) span = SPAN_MAX;
      r.span = 22'(span);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus side

  function automatic date_req_t make_request(input logic [2:0] k, input logic [4:0] d1,
                                             input logic [3:0] m1, input logic [13:0] y1,
                                             input logic [4:0] d2, input logic [3:0] m2,
                                             input logic [13:0] y2, input logic [15:0] n);
    date_req_t req;
    req.kind  = k;
    req.d1    = d1;
    req.m1    = m1;
    req.y1    = y1;
    req.d2    = d2;
    req.m2    = m2;
    req.y2    = y2;
    req.steps = n;
    return req;
  endfunction

  // Presents one transaction, holds it until accepted, then keeps the burst going or
  // drops valid for a random gap.
  task automatic send_request(input date_req_t req);
    req_valid <= 1'b1;
    req_kind  <= req.kind;
    req_d1    <= req.d1;
    req_m1    <= req.m1;
    req_y1    <= req.y1;
    req_d2    <= req.d2;
    req_m2    <= req.m2;
    req_y2    <= req.y2;
    req_steps <= req.steps;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_date_op(req));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic void pick_date(input bit raw, output logic [4:0] d,
                                    output logic [3:0] m, output logic [13:0] y);
    int unsigned yy, mm;
    if (raw) begin
      d = 5'($urandom_range(0, 31));
      m = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 2))
        0:       y = 14'd0;
        1:       y = 14'($urandom_range(YEAR_LIMIT + 1, 16383));
        default: y = 14'($urandom_range(0, 16383));
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0:       yy = $urandom_range(1, 4);
        1:       yy = $urandom_range(YEAR_LIMIT - 3, YEAR_LIMIT);
        2:       yy = 100 * $urandom_range(1, 99);
        default: yy = $urandom_range(1, YEAR_LIMIT);
      endcase
      mm = $urandom_range(1, 12);
      y  = 14'(yy);
      m  = 4'(mm);
      d  = 5'(($urandom_range(0, 3) == 0) ? days_in(mm, yy)
                                          : $urandom_range(1, days_in(mm, yy)));
    end
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_step_forward();
    send_request(make_request(KIND_ADD_DAYS, 15, 6, 2023, 1, 1, 1, 0));
    send_request(make_request(KIND_ADD_DAYS, 28, 2, 2024, 1, 1, 1, 1));
    send_request(make_request(KIND_ADD_DAYS, 28, 2, 1900, 1, 1, 1, 1));
    send_request(make_request(KIND_ADD_DAYS, 1, 1, 1, 1, 1, 1, 16'hFFFF));
    send_request(make_request(KIND_ADD_DAYS, 31, 12, YEAR_LIMIT, 1, 1, 1, 1));
    wait_for_results();
  endtask

  task automatic test_step_back();
    send_request(make_request(KIND_SUB_DAYS, 1, 3, 2000, 1, 1, 1, 1));
    send_request(make_request(KIND_SUB_DAYS, 1, 3, 2100, 1, 1, 1, 1));
    send_request(make_request(KIND_SUB_DAYS, 1, 5, 2023, 1, 1, 1, 1));
    send_request(make_request(KIND_SUB_DAYS, 1, 1, 2001, 1, 1, 1, 1));
    send_request(make_request(KIND_SUB_DAYS, 1, 1, 1, 1, 1, 1, 1));
    send_request(make_request(KIND_SUB_DAYS, 31, 12, YEAR_LIMIT, 1, 1, 1, 16'hFFFF));
    wait_for_results();
  endtask

  task automatic test_day_span();
    send_request(make_request(KIND_DAY_SPAN, 1, 1, 1, 31, 12, YEAR_LIMIT, 0));
    send_request(make_request(KIND_DAY_SPAN, 1, 3, 2000, 28, 2, 2000, 0));
    send_request(make_request(KIND_DAY_SPAN, 7, 7, 1777, 7, 7, 1777, 0));
    wait_for_results();
  endtask

  task automatic test_year_month_span();
    send_request(make_request(KIND_YEAR_SPAN, 15, 6, 2000, 14, 6, 2010, 0));
    send_request(make_request(KIND_YEAR_SPAN, 28, 2, 2001, 29, 2, 2000, 0));
    send_request(make_request(KIND_YEAR_SPAN, 1, 1, 1, 31, 12, YEAR_LIMIT, 0));
    send_request(make_request(KIND_MONTH_SPAN, 31, 1, 2023, 28, 2, 2023, 0));
    send_request(make_request(KIND_MONTH_SPAN, 15, 3, 2024, 15, 1, 2020, 0));
    send_request(make_request(KIND_MONTH_SPAN, 1, 1, 1, 31, 12, YEAR_LIMIT, 0));
    wait_for_results();
  endtask

  // Out-of-range date fields are clamped; spare kind codes give all-zero results.
  task automatic test_field_clamping();
    send_request(make_request(KIND_ADD_DAYS, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(KIND_ADD_DAYS, 31, 15, 16383, 31, 15, 16383, 0));
    send_request(make_request(KIND_SUB_DAYS, 31, 2, 2023, 0, 0, 0, 0));
    send_request(make_request(KIND_YEAR_SPAN, 0, 13, 16383, 31, 0, 0, 0));
    send_request(make_request(KIND_SPARE_LO, 31, 15, 16383, 31, 15, 16383, 16'hFFFF));
    send_request(make_request(KIND_SPARE_LO + 3'd1, 1, 1, 1, 1, 1, 1, 1));
    send_request(make_request(KIND_SPARE_HI, 31, 15, 16383, 31, 15, 16383, 16'hFFFF));
    wait_for_results();
  endtask

  task automatic test_random_mix();
    date_req_t req;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        req.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end else begin
        req.kind = 3'($urandom_range(KIND_ADD_DAYS, KIND_MONTH_SPAN));
      end
      pick_date($urandom_range(0, 7) == 0, req.d1, req.m1, req.y1);
      pick_date($urandom_range(0, 7) == 0, req.d2, req.m2, req.y2);
      // Long steps are rare so that the run stays short.
      case ($urandom_range(0, 15))
        0:       req.steps = 16'($urandom_range(0, 65535));
        1, 2:    req.steps = 16'($urandom_range(0, 3));
        default: req.steps = 16'($urandom_range(0, 1500));
      endcase
      if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 39) == 0) wait_for_results();
      send_request(req);
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(4, 40);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       res_stall <= 1'b0;
        1:       res_stall <= 1'($urandom_range(0, 1));
        default: res_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic void compare_field(input string field, input int unsigned want_v,
                                        input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    date_result_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d span %0d err %0d",
                 $time, res_year, res_month, res_day, res_span, res_error);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("result_day", want.at.day, res_day);
        compare_field("result_month", want.at.month, res_month);
        compare_field("result_year", want.at.year, res_year);
        compare_field("span", want.span, res_span);
        compare_field("range_error", want.range_error, res_error);
      end
    end
  end

  // ---------------------------------------------------------------- sequencing

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_step_forward();
    test_step_back();
    test_day_span();
    test_year_month_span();
    test_field_clamping();
    test_random_mix();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/gda_pkg.sv
rtl/gda_leap.sv
rtl/gda_mac.sv
rtl/gregorian_date_arithmetic_top.sv
verif/tb_top.sv
